[design/i64alu_pkg.sv]
// Package for the 64-bit integer ALU with null flags.
// Holds opcodes, the default data width and the pipeline control struct.
package i64alu_pkg;

  localparam int DefaultDataWidth = 64;
  localparam int PortWidth = 64;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_NEG = 5'd5, OP_EQ = 5'd6, OP_NE = 5'd7, OP_LT = 5'd8, OP_LE = 5'd9,
    OP_GT = 5'd10, OP_GE = 5'd11, OP_NOT = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14,
    OP_XOR = 5'd15, OP_LSH = 5'd16, OP_RSH = 5'd17
  } opcode_t;

  // Control carried with each beat down the cell chain
  typedef struct packed {
    logic       valid;
    logic       is_div;   // divide/modulo beat, result taken from the chain
    logic       is_mod;
    logic       is_mul;   // multiply beat, product accumulated in the chain
    logic       q_neg;    // negate quotient (or product) at the end
    logic       r_neg;    // negate remainder at the end
    logic       rnull;
    logic       status;
  } ctl_t;

endpackage

[design/i64alu_div_cell.sv]
// One chain cell: decides one quotient bit, or adds one partial product, per beat.
// Depends on i64alu_pkg for the control struct.
module i64alu_div_cell #(
  parameter int W = 64,
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  i64alu_pkg::ctl_t  ctl_in,
  input  logic [W-1:0]      rem_in,
  input  logic [W-1:0]      quo_in,
  input  logic [W-1:0]      div_in,
  input  logic [W-1:0]      val_in,
  output i64alu_pkg::ctl_t  ctl_out,
  output logic [W-1:0]      rem_out,
  output logic [W-1:0]      quo_out,
  output logic [W-1:0]      div_out,
  output logic [W-1:0]      val_out
);
  import i64alu_pkg::*;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic [W-1:0] acc_next;

  // Shift in the next dividend bit (held in quo) and try to subtract
  always_comb begin
    trial = {rem_in, quo_in[BIT]};
    diff = trial - {1'b0, div_in};
    quo_next = quo_in;
    if (!diff[W]) begin
      rem_next = diff[W-1:0];
      quo_next[BIT] = 1'b1;
    end else begin
      rem_next = trial[W-1:0];
      quo_next[BIT] = 1'b0;
    end
  end

  // Add the partial product for this multiplier bit (accumulator held in rem)
  assign acc_next = rem_in + (div_in << BIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Advance payload; other beats pass their value through
  always_ff @(posedge clk) begin
    if (ctl_in.is_div) begin
      rem_out <= rem_next;
    end else if (ctl_in.is_mul && quo_in[BIT]) begin
      rem_out <= acc_next;
    end else begin
      rem_out <= rem_in;
    end
    quo_out <= ctl_in.is_div ? quo_next : quo_in;
    div_out <= div_in;
    val_out <= val_in;
  end

endmodule

[design/int64_alu_with_null.sv]
// 64-bit integer ALU with SQL-style null flags.
// Path: stage 0, stage 1, the cell chain, then the output register, every op alike.
// Throughput: one beat per cycle; busy stays low. Multiply and divide run down a
//   chain of DATA_WIDTH cells, one bit each, so a new beat enters every cycle.
// Reset: rst (synchronous) clears all valid bits; no result strobes after it.
// Results appear on done for one cycle; the receiver cannot stall.
module int64_alu_with_null #(
  parameter int DATA_WIDTH = i64alu_pkg::DefaultDataWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [4:0]                        opcode,
  input  logic signed [i64alu_pkg::PortWidth-1:0] a_value,
  input  logic                              a_null,
  input  logic signed [i64alu_pkg::PortWidth-1:0] b_value,
  input  logic                              b_null,
  output logic                              done,
  output logic signed [i64alu_pkg::PortWidth-1:0] result_value,
  output logic                              result_null,
  output logic                              status
);
  import i64alu_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int P = PortWidth;

  // ---------------- stage 0: register operands ----------------
  logic          s0_valid;
  logic [4:0]    s0_op;
  logic [W-1:0]  s0_a, s0_b;
  logic [7:0]    s0_sh;
  logic          s0_null;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_op <= opcode;
    s0_a  <= a_value[W-1:0];
    s0_b  <= b_value[W-1:0];
    s0_sh <= b_value[7:0];
    s0_null <= a_null | (b_null & !(opcode == OP_NEG || opcode == OP_NOT));
  end

  // ---------------- stage 1: everything but multiply and division ----------------
  logic [W-1:0] alu_r;
  logic         lt, gt;
  logic [W-1:0] mag_a, mag_b;
  logic         known;

  always_comb begin
    lt = $signed(s0_a) < $signed(s0_b);
    gt = $signed(s0_b) < $signed(s0_a);
    mag_a = s0_a[W-1] ? (~s0_a + 1'b1) : s0_a;
    mag_b = s0_b[W-1] ? (~s0_b + 1'b1) : s0_b;
    known = (s0_op <= OP_RSH);
    alu_r = '0;
    case (s0_op)
      OP_ADD: alu_r = s0_a + s0_b;
      OP_SUB: alu_r = s0_a - s0_b;
      OP_NEG: alu_r = '0 - s0_a;
      OP_EQ:  alu_r = W'(s0_a == s0_b);
      OP_NE:  alu_r = W'(s0_a != s0_b);
      OP_LT:  alu_r = W'(lt);
      OP_LE:  alu_r = W'(!gt);
      OP_GT:  alu_r = W'(gt);
      OP_GE:  alu_r = W'(!lt);
      OP_NOT: alu_r = ~s0_a;
      OP_AND: alu_r = s0_a & s0_b;
      OP_OR:  alu_r = s0_a | s0_b;
      OP_XOR: alu_r = s0_a ^ s0_b;
      OP_LSH: alu_r = (32'(s0_sh) >= W) ? '0 : (s0_a << s0_sh);
      OP_RSH: alu_r = (32'(s0_sh) >= W) ? {W{s0_a[W-1]}}
                                      : W'($signed(s0_a) >>> s0_sh);
      default: alu_r = '0;
    endcase
  end

  ctl_t          s1_ctl;
  logic [W-1:0]  s1_val, s1_div, s1_dvd;
  logic          is_dm;

  assign is_dm = (s0_op == OP_DIV || s0_op == OP_MOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid  <= s0_valid;
      s1_ctl.rnull  <= known & s0_null;
      s1_ctl.status <= !s0_null & is_dm & (s0_b == '0);
      s1_ctl.is_div <= !s0_null & is_dm & (s0_b != '0);
      s1_ctl.is_mod <= s0_op == OP_MOD;
      s1_ctl.is_mul <= !s0_null & (s0_op == OP_MUL);
      s1_ctl.q_neg  <= s0_a[W-1] ^ s0_b[W-1];
      s1_ctl.r_neg  <= s0_a[W-1];
    end
  end

  // Magnitudes feed both the divider and the multiplier
  always_ff @(posedge clk) begin
    s1_val <= alu_r;
    s1_div <= mag_b;
    s1_dvd <= mag_a;
  end

  // ---------------- cell chain: one cell per quotient or multiplier bit ----------------
  ctl_t         c_ctl [W+1];
  logic [W-1:0] c_rem [W+1];
  logic [W-1:0] c_quo [W+1];
  logic [W-1:0] c_div [W+1];
  logic [W-1:0] c_val [W+1];

  assign c_ctl[0] = s1_ctl;
  assign c_rem[0] = '0;
  assign c_quo[0] = s1_dvd;
  assign c_div[0] = s1_div;
  assign c_val[0] = s1_val;

  for (genvar i = 0; i < W; i++) begin : g_cell
    i64alu_div_cell #(.W(W), .BIT(W - 1 - i)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(c_ctl[i]), .rem_in(c_rem[i]), .quo_in(c_quo[i]),
      .div_in(c_div[i]), .val_in(c_val[i]),
      .ctl_out(c_ctl[i+1]), .rem_out(c_rem[i+1]), .quo_out(c_quo[i+1]),
      .div_out(c_div[i+1]), .val_out(c_val[i+1])
    );
  end

  // ---------------- output stage: sign fix and null/error zeroing ----------------
  ctl_t         e_ctl;
  logic [W-1:0] e_r;

  assign e_ctl = c_ctl[W];

  always_comb begin
    if (e_ctl.rnull || e_ctl.status) begin
      e_r = '0;
    end else if (e_ctl.is_div && e_ctl.is_mod) begin
      e_r = e_ctl.r_neg ? '0 - c_rem[W] : c_rem[W];
    end else if (e_ctl.is_div) begin
      e_r = e_ctl.q_neg ? '0 - c_quo[W] : c_quo[W];
    end else if (e_ctl.is_mul) begin
      e_r = e_ctl.q_neg ? '0 - c_rem[W] : c_rem[W];
    end else begin
      e_r = c_val[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= P'($signed(e_r));
    result_null  <= e_ctl.rnull;
    status       <= e_ctl.status;
  end

  // Null and error never both flag a beat
  assert property (@(posedge clk) disable iff (rst) done |-> !(result_null && status))
    else $error("null and error both set");
  // A null or error result carries zero
  assert property (@(posedge clk) disable iff (rst)
    done && (result_null || status) |-> result_value == '0)
    else $error("flagged result not zero");
  // A divide beat never reports a zero divisor
  assert property (@(posedge clk) disable iff (rst) e_ctl.is_div |-> !e_ctl.status)
    else $error("divide beat flagged as error");

endmodule
